// ===== rtl/crc_frame_receiver_classifier_assert.svh =====
// Assertion macros for the frame receiver datapath.
`ifndef CRC_FRAME_RECEIVER_CLASSIFIER_ASSERT_SVH
`define CRC_FRAME_RECEIVER_CLASSIFIER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define CRCFR_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("crcfr invariant violated");

// Check that a trigger implies a condition in the same cycle.
`define CRCFR_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("crcfr same-cycle check failed");

// Check that a trigger implies a condition in the next cycle.
`define CRCFR_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("crcfr next-cycle check failed");

`endif

// ===== rtl/crcfr_pkg.sv =====
// Shared types, constants and functions of the framed request receiver.
`default_nettype none

package crcfr_pkg;

  localparam int STORE_BYTES_DEF = 64;
  localparam int MAX_PAYLOAD_DEF = 40;
  localparam int MAX_RESULTS     = 64;

  localparam logic [7:0]  MAGIC0   = 8'hAA;
  localparam logic [7:0]  MAGIC1   = 8'h55;
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Protobuf wire types
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // Request kinds
  localparam logic [2:0] KIND_PASS   = 3'd0;
  localparam logic [2:0] KIND_INFO   = 3'd1;
  localparam logic [2:0] KIND_STATUS = 3'd2;
  localparam logic [2:0] KIND_CLEAR  = 3'd3;
  localparam logic [2:0] KIND_OTHER  = 3'd4;

  // Field numbers
  localparam logic [28:0] FLD_DATA   = 29'd1;
  localparam logic [28:0] FLD_STATUS = 29'd2;
  localparam logic [28:0] FLD_PASS   = 29'd3;
  localparam logic [28:0] FLD_INFO   = 29'd4;
  localparam logic [28:0] FLD_CLEAR  = 29'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_last;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] req_kind;
    logic [5:0] payload_len;
    logic       has_byte;
    logic [7:0] payload_byte;
    logic       last;
  } out_beat_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_PUSH,
    OP_READ,
    OP_READ_INC,
    OP_CUR_SET,
    OP_CUR_INC,
    OP_CUR_ADD,
    OP_CUR_ADD_ACC,
    OP_DROP_CUR,
    OP_DROP_IMM,
    OP_DROP_FRAME,
    OP_LATCH_HI,
    OP_LATCH_LO,
    OP_CRC_INIT,
    OP_CRC_BYTE,
    OP_LATCH_GOT,
    OP_VI_INIT,
    OP_VI_ACC,
    OP_KEY_LATCH,
    OP_SET_KIND,
    OP_END_INNER,
    OP_SET_DATA,
    OP_EMIT_HDR,
    OP_EMIT_BYTE
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] imm;
  } dp_cmd_t;

  typedef struct packed {
    logic       rd_aa;
    logic       rd_55;
    logic       rd_more;
    logic       cnt_lt4;
    logic       cur_lt_cnt;
    logic       cur_lt_end;
    logic       blen_bad;
    logic       frame_short;
    logic       crc_ok;
    logic       len_over;
    logic       vi_full;
    logic [2:0] key_wt;
    logic       fld_data;
    logic       fld_status;
    logic       fld_pass;
    logic       fld_info;
    logic       fld_clear;
    logic       n_full;
    logic       i_lt_nb;
    logic       out_free;
    logic       report_en;
  } dp_stat_t;

  // CRC-16/CCITT-FALSE update by one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/crcfr_dp.sv =====
// Datapath: circular frame store, read port, CRC, varint unit and result register.
`default_nettype none

module crcfr_dp #(
  parameter int STORE_BYTES = crcfr_pkg::STORE_BYTES_DEF,
  parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  crcfr_pkg::dp_cmd_t   cmd,
  output crcfr_pkg::dp_stat_t  stat,
  input  wire  [7:0]           in_byte,
  input  wire                  cfg_we,
  input  wire                  cfg_wdata,
  output logic                 out_valid,
  input  wire                  out_ready,
  output crcfr_pkg::out_beat_t out_data
);

  localparam int AW   = $clog2(STORE_BYTES);
  localparam int CNTW = $clog2(STORE_BYTES + 1);
  localparam int CW   = AW + 2;
  localparam logic [16:0] BLEN_MAX = 17'(MAX_PAYLOAD + 16);

  logic [7:0]      mem [STORE_BYTES];
  logic [AW-1:0]   head_r, head_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            report_r;
  logic            out_valid_r;
  crcfr_pkg::out_beat_t out_r;

  logic [7:0]      rd_r;
  logic [CW-1:0]   cur_r;
  logic [CW-1:0]   end_r;
  logic [31:0]     acc_r;
  logic [2:0]      sh_r;
  logic [31:0]     key_r;
  logic [15:0]     blen_r;
  logic [15:0]     crc_r;
  logic [7:0]      got_r;
  logic [2:0]      kind_r;
  logic [5:0]      dl_r;
  logic [CW-1:0]   ds_r;
  logic [6:0]      n_r;
  logic [5:0]      i_r;
  logic [5:0]      nb_r;

  logic [AW-1:0]   raddr;
  logic [AW-1:0]   waddr;
  logic [CW-1:0]   drop_n;
  logic [CW-1:0]   drop_eff;
  logic            full;
  logic            emit;
  logic [5:0]      room;
  logic [5:0]      nb_calc;
  logic [5:0]      acc_sat;
  logic [31:0]     acc_part;

  // Wrap a store offset around the circular buffer
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(h) + (CW+1)'(off);
    if (sum >= (CW+1)'(STORE_BYTES)) sum = sum - (CW+1)'(STORE_BYTES);
    return sum[AW-1:0];
  endfunction

  assign full  = (cnt_r == CNTW'(STORE_BYTES));
  assign raddr = wrap_add(head_r, cur_r);
  assign waddr = full ? head_r : wrap_add(head_r, CW'(cnt_r));
  assign emit  = (cmd.op == crcfr_pkg::OP_EMIT_HDR) || (cmd.op == crcfr_pkg::OP_EMIT_BYTE);

  // Pick the drop amount and clamp to the fill
  always_comb begin
    case (cmd.op)
      crcfr_pkg::OP_DROP_CUR:   drop_n = cur_r;
      crcfr_pkg::OP_DROP_IMM:   drop_n = CW'(cmd.imm);
      crcfr_pkg::OP_DROP_FRAME: drop_n = CW'(blen_r + 16'd6);
      default:                  drop_n = '0;
    endcase
    drop_eff = (drop_n >= CW'(cnt_r)) ? CW'(cnt_r) : drop_n;
  end

  // Advance head and fill count
  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    case (cmd.op)
      crcfr_pkg::OP_PUSH: begin
        if (full) head_nxt = wrap_add(head_r, CW'(1));
        else cnt_nxt = cnt_r + CNTW'(1);
      end
      crcfr_pkg::OP_DROP_CUR, crcfr_pkg::OP_DROP_IMM, crcfr_pkg::OP_DROP_FRAME: begin
        head_nxt = wrap_add(head_r, drop_eff);
        cnt_nxt  = cnt_r - CNTW'(drop_eff);
      end
      default: ;
    endcase
  end

  // Result sizing and varint slice
  assign room    = 6'd63 - n_r[5:0];
  assign nb_calc = (dl_r < room) ? dl_r : room;
  assign acc_sat = (acc_r > 32'd63) ? 6'd63 : acc_r[5:0];

  always_comb begin
    case (sh_r)
      3'd0:    acc_part = {25'd0, rd_r[6:0]};
      3'd1:    acc_part = {18'd0, rd_r[6:0], 7'd0};
      3'd2:    acc_part = {11'd0, rd_r[6:0], 14'd0};
      3'd3:    acc_part = {4'd0, rd_r[6:0], 21'd0};
      default: acc_part = {rd_r[3:0], 28'd0};
    endcase
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.op == crcfr_pkg::OP_PUSH) mem[waddr] <= in_byte;
    if (cmd.op == crcfr_pkg::OP_READ || cmd.op == crcfr_pkg::OP_READ_INC) rd_r <= mem[raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      cnt_r       <= '0;
      report_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      if (cfg_we) report_r <= cfg_wdata;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      crcfr_pkg::OP_PUSH:        n_r <= '0;
      crcfr_pkg::OP_READ_INC:    cur_r <= cur_r + CW'(1);
      crcfr_pkg::OP_CUR_SET:     cur_r <= CW'(cmd.imm);
      crcfr_pkg::OP_CUR_INC:     cur_r <= cur_r + CW'(1);
      crcfr_pkg::OP_CUR_ADD:     cur_r <= cur_r + CW'(cmd.imm);
      crcfr_pkg::OP_CUR_ADD_ACC: cur_r <= cur_r + acc_r[CW-1:0];
      crcfr_pkg::OP_LATCH_HI:    blen_r[15:8] <= rd_r;
      crcfr_pkg::OP_LATCH_LO:    blen_r[7:0] <= rd_r;
      crcfr_pkg::OP_CRC_INIT: begin
        crc_r <= crcfr_pkg::CRC_SEED;
        cur_r <= CW'(4);
        end_r <= CW'(blen_r + 16'd4);
      end
      crcfr_pkg::OP_CRC_BYTE:    crc_r <= crcfr_pkg::crc16_byte(crc_r, rd_r);
      crcfr_pkg::OP_LATCH_GOT:   got_r <= rd_r;
      crcfr_pkg::OP_VI_INIT: begin
        acc_r <= '0;
        sh_r  <= '0;
      end
      crcfr_pkg::OP_VI_ACC: begin
        acc_r <= acc_r | acc_part;
        sh_r  <= sh_r + 3'd1;
      end
      crcfr_pkg::OP_KEY_LATCH:   key_r <= acc_r;
      crcfr_pkg::OP_SET_KIND: begin
        kind_r <= cmd.imm[2:0];
        dl_r   <= '0;
        ds_r   <= '0;
      end
      crcfr_pkg::OP_END_INNER: begin
        end_r  <= cur_r + acc_r[CW-1:0];
        kind_r <= crcfr_pkg::KIND_PASS;
        dl_r   <= '0;
        ds_r   <= '0;
      end
      crcfr_pkg::OP_SET_DATA: begin
        ds_r <= cur_r;
        dl_r <= acc_sat;
      end
      crcfr_pkg::OP_EMIT_HDR: begin
        out_r <= '{req_kind: kind_r, payload_len: dl_r, has_byte: 1'b0,
                   payload_byte: 8'h00, last: (nb_calc == 6'd0)};
        nb_r  <= nb_calc;
        i_r   <= '0;
        n_r   <= n_r + 7'd1;
        cur_r <= ds_r;
      end
      crcfr_pkg::OP_EMIT_BYTE: begin
        out_r <= '{req_kind: kind_r, payload_len: dl_r, has_byte: 1'b1,
                   payload_byte: rd_r, last: ((i_r + 6'd1) == nb_r)};
        i_r   <= i_r + 6'd1;
        n_r   <= n_r + 7'd1;
      end
      default: ;
    endcase
  end

  // Status back to the controller
  always_comb begin
    stat.rd_aa       = (rd_r == crcfr_pkg::MAGIC0);
    stat.rd_55       = (rd_r == crcfr_pkg::MAGIC1);
    stat.rd_more     = rd_r[7];
    stat.cnt_lt4     = (cnt_r < CNTW'(4));
    stat.cur_lt_cnt  = (cur_r < CW'(cnt_r));
    stat.cur_lt_end  = (cur_r < end_r);
    stat.blen_bad    = ({1'b0, blen_r} > BLEN_MAX);
    stat.frame_short = (17'(cnt_r) < ({1'b0, blen_r} + 17'd6));
    stat.crc_ok      = (crc_r == {got_r, rd_r});
    stat.len_over    = (({1'b0, acc_r} + 33'(cur_r)) > 33'(end_r));
    stat.vi_full     = (sh_r == 3'd5);
    stat.key_wt      = key_r[2:0];
    stat.fld_data    = (key_r[31:3] == crcfr_pkg::FLD_DATA);
    stat.fld_status  = (key_r[31:3] == crcfr_pkg::FLD_STATUS);
    stat.fld_pass    = (key_r[31:3] == crcfr_pkg::FLD_PASS);
    stat.fld_info    = (key_r[31:3] == crcfr_pkg::FLD_INFO);
    stat.fld_clear   = (key_r[31:3] == crcfr_pkg::FLD_CLEAR);
    stat.n_full      = (n_r >= 7'(crcfr_pkg::MAX_RESULTS));
    stat.i_lt_nb     = (i_r < nb_r);
    stat.out_free    = !out_valid_r || out_ready;
    stat.report_en   = report_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "crc_frame_receiver_classifier_assert.svh"

  `CRCFR_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNTW'(STORE_BYTES))
  `CRCFR_ASSERT_SAME(a_emit_slot, emit, !out_valid_r || out_ready)
  `CRCFR_ASSERT_NEXT(a_push_fill, cmd.op == crcfr_pkg::OP_PUSH, cnt_r != '0)
  `CRCFR_ASSERT_NEXT(a_emit_shown, emit, out_valid_r)

endmodule

`default_nettype wire

// ===== rtl/crcfr_ctrl.sv =====
// Controller: sequences resync, length and CRC checks, protobuf walk and emission.
`default_nettype none

module crcfr_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  crcfr_pkg::dp_stat_t stat,
  output crcfr_pkg::dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_TOP, S_R0, S_C0, S_C1, S_SCAN, S_SCANCHK, S_POSTDROP, S_PD_R, S_PD_C,
    S_L2, S_L3R, S_L3, S_LCHK, S_CRC, S_CRCB, S_GH, S_GLR, S_GL, S_DONE,
    S_TK, S_VI, S_VA, S_VR, S_TW, S_IK, S_IW, S_EMIT_HDR, S_EMIT, S_EB
  } state_t;

  typedef enum logic [2:0] {
    CTX_TOPKEY, CTX_TOPVAL, CTX_TOPLEN, CTX_INKEY, CTX_INVAL, CTX_INLEN
  } ctx_t;

  state_t state_r, state_nxt;
  ctx_t   ctx_r, ctx_nxt;
  logic   inner_r, inner_nxt;

  // Next state and datapath command
  always_comb begin
    state_nxt = state_r;
    ctx_nxt   = ctx_r;
    inner_nxt = inner_r;
    cmd       = '{op: crcfr_pkg::OP_NONE, imm: 4'd0};
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = crcfr_pkg::OP_PUSH;
          state_nxt = S_TOP;
        end
      end
      // Loop head: need a full header to look at
      S_TOP: begin
        if (stat.cnt_lt4) state_nxt = S_IDLE;
        else begin
          cmd       = '{op: crcfr_pkg::OP_CUR_SET, imm: 4'd0};
          state_nxt = S_R0;
        end
      end
      S_R0: begin
        cmd.op    = crcfr_pkg::OP_READ_INC;
        state_nxt = S_C0;
      end
      S_C0: begin
        if (stat.rd_aa) begin
          cmd.op    = crcfr_pkg::OP_READ_INC;
          state_nxt = S_C1;
        end else state_nxt = S_SCAN;
      end
      S_C1: begin
        if (stat.rd_55) begin
          cmd.op    = crcfr_pkg::OP_READ_INC;
          state_nxt = S_L2;
        end else begin
          cmd       = '{op: crcfr_pkg::OP_CUR_SET, imm: 4'd1};
          state_nxt = S_SCAN;
        end
      end
      // Hunt for the next AA, then drop everything before it
      S_SCAN: begin
        if (stat.cur_lt_cnt) begin
          cmd.op    = crcfr_pkg::OP_READ;
          state_nxt = S_SCANCHK;
        end else begin
          cmd.op    = crcfr_pkg::OP_DROP_CUR;
          state_nxt = S_POSTDROP;
        end
      end
      S_SCANCHK: begin
        if (stat.rd_aa) begin
          cmd.op    = crcfr_pkg::OP_DROP_CUR;
          state_nxt = S_POSTDROP;
        end else begin
          cmd.op    = crcfr_pkg::OP_CUR_INC;
          state_nxt = S_SCAN;
        end
      end
      S_POSTDROP: begin
        if (stat.cnt_lt4) state_nxt = S_IDLE;
        else begin
          cmd       = '{op: crcfr_pkg::OP_CUR_SET, imm: 4'd1};
          state_nxt = S_PD_R;
        end
      end
      S_PD_R: begin
        cmd.op    = crcfr_pkg::OP_READ_INC;
        state_nxt = S_PD_C;
      end
      S_PD_C: begin
        if (stat.rd_55) begin
          cmd.op    = crcfr_pkg::OP_READ_INC;
          state_nxt = S_L2;
        end else begin
          cmd       = '{op: crcfr_pkg::OP_DROP_IMM, imm: 4'd1};
          state_nxt = S_TOP;
        end
      end
      // Body length, big endian
      S_L2: begin
        cmd.op    = crcfr_pkg::OP_LATCH_HI;
        state_nxt = S_L3R;
      end
      S_L3R: begin
        cmd.op    = crcfr_pkg::OP_READ_INC;
        state_nxt = S_L3;
      end
      S_L3: begin
        cmd.op    = crcfr_pkg::OP_LATCH_LO;
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        if (stat.blen_bad) begin
          cmd       = '{op: crcfr_pkg::OP_DROP_IMM, imm: 4'd2};
          state_nxt = S_TOP;
        end else if (stat.frame_short) state_nxt = S_IDLE;
        else begin
          cmd.op    = crcfr_pkg::OP_CRC_INIT;
          state_nxt = S_CRC;
        end
      end
      // CRC over the body, one byte per read
      S_CRC: begin
        cmd.op    = crcfr_pkg::OP_READ_INC;
        state_nxt = stat.cur_lt_end ? S_CRCB : S_GH;
      end
      S_CRCB: begin
        cmd.op    = crcfr_pkg::OP_CRC_BYTE;
        state_nxt = S_CRC;
      end
      S_GH: begin
        cmd.op    = crcfr_pkg::OP_LATCH_GOT;
        state_nxt = S_GLR;
      end
      S_GLR: begin
        cmd.op    = crcfr_pkg::OP_READ_INC;
        state_nxt = S_GL;
      end
      S_GL: begin
        if (!stat.crc_ok) begin
          cmd       = '{op: crcfr_pkg::OP_DROP_IMM, imm: 4'd2};
          state_nxt = S_TOP;
        end else if (stat.report_en) begin
          cmd       = '{op: crcfr_pkg::OP_CUR_SET, imm: 4'd4};
          inner_nxt = 1'b0;
          state_nxt = S_TK;
        end else state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.op    = crcfr_pkg::OP_DROP_FRAME;
        state_nxt = S_TOP;
      end
      // Top-level field walk
      S_TK: begin
        if (stat.cur_lt_end) begin
          cmd.op    = crcfr_pkg::OP_VI_INIT;
          ctx_nxt   = CTX_TOPKEY;
          state_nxt = S_VI;
        end else state_nxt = S_DONE;
      end
      // Shared varint decoder
      S_VI: begin
        if (stat.cur_lt_end && !stat.vi_full) begin
          cmd.op    = crcfr_pkg::OP_READ_INC;
          state_nxt = S_VA;
        end else state_nxt = inner_r ? S_EMIT_HDR : S_DONE;
      end
      S_VA: begin
        cmd.op    = crcfr_pkg::OP_VI_ACC;
        state_nxt = stat.rd_more ? S_VI : S_VR;
      end
      S_VR: begin
        unique case (ctx_r)
          CTX_TOPKEY: begin
            cmd.op    = crcfr_pkg::OP_KEY_LATCH;
            state_nxt = S_TW;
          end
          CTX_TOPVAL: state_nxt = S_TK;
          CTX_TOPLEN: begin
            if (stat.len_over) state_nxt = S_DONE;
            else if (stat.fld_pass) begin
              cmd.op    = crcfr_pkg::OP_END_INNER;
              inner_nxt = 1'b1;
              state_nxt = S_IK;
            end else begin
              cmd.op = crcfr_pkg::OP_SET_KIND;
              if (stat.fld_info) cmd.imm = {1'b0, crcfr_pkg::KIND_INFO};
              else if (stat.fld_status) cmd.imm = {1'b0, crcfr_pkg::KIND_STATUS};
              else if (stat.fld_clear) cmd.imm = {1'b0, crcfr_pkg::KIND_CLEAR};
              else cmd.imm = {1'b0, crcfr_pkg::KIND_OTHER};
              state_nxt = S_EMIT_HDR;
            end
          end
          CTX_INKEY: begin
            cmd.op    = crcfr_pkg::OP_KEY_LATCH;
            state_nxt = S_IW;
          end
          CTX_INVAL: state_nxt = S_IK;
          CTX_INLEN: begin
            if (stat.len_over) state_nxt = S_EMIT_HDR;
            else if (stat.fld_data) begin
              cmd.op    = crcfr_pkg::OP_SET_DATA;
              state_nxt = S_EMIT_HDR;
            end else begin
              cmd.op    = crcfr_pkg::OP_CUR_ADD_ACC;
              state_nxt = S_IK;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_TW: begin
        case (stat.key_wt)
          crcfr_pkg::WT_VARINT: begin
            cmd.op    = crcfr_pkg::OP_VI_INIT;
            ctx_nxt   = CTX_TOPVAL;
            state_nxt = S_VI;
          end
          crcfr_pkg::WT_LEN: begin
            cmd.op    = crcfr_pkg::OP_VI_INIT;
            ctx_nxt   = CTX_TOPLEN;
            state_nxt = S_VI;
          end
          crcfr_pkg::WT_FIXED32: begin
            cmd       = '{op: crcfr_pkg::OP_CUR_ADD, imm: 4'd4};
            state_nxt = S_TK;
          end
          crcfr_pkg::WT_FIXED64: begin
            cmd       = '{op: crcfr_pkg::OP_CUR_ADD, imm: 4'd8};
            state_nxt = S_TK;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      // Inner walk of the passthrough message
      S_IK: begin
        if (stat.cur_lt_end) begin
          cmd.op    = crcfr_pkg::OP_VI_INIT;
          ctx_nxt   = CTX_INKEY;
          state_nxt = S_VI;
        end else state_nxt = S_EMIT_HDR;
      end
      S_IW: begin
        case (stat.key_wt)
          crcfr_pkg::WT_VARINT: begin
            cmd.op    = crcfr_pkg::OP_VI_INIT;
            ctx_nxt   = CTX_INVAL;
            state_nxt = S_VI;
          end
          crcfr_pkg::WT_LEN: begin
            cmd.op    = crcfr_pkg::OP_VI_INIT;
            ctx_nxt   = CTX_INLEN;
            state_nxt = S_VI;
          end
          crcfr_pkg::WT_FIXED32: begin
            cmd       = '{op: crcfr_pkg::OP_CUR_ADD, imm: 4'd4};
            state_nxt = S_IK;
          end
          crcfr_pkg::WT_FIXED64: begin
            cmd       = '{op: crcfr_pkg::OP_CUR_ADD, imm: 4'd8};
            state_nxt = S_IK;
          end
          default: state_nxt = S_EMIT_HDR;
        endcase
      end
      // Header beat, then data beats
      S_EMIT_HDR: begin
        if (stat.n_full) state_nxt = S_DONE;
        else if (stat.out_free) begin
          cmd.op    = crcfr_pkg::OP_EMIT_HDR;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.i_lt_nb) begin
          cmd.op    = crcfr_pkg::OP_READ_INC;
          state_nxt = S_EB;
        end else state_nxt = S_DONE;
      end
      S_EB: begin
        if (stat.out_free) begin
          cmd.op    = crcfr_pkg::OP_EMIT_BYTE;
          state_nxt = S_EMIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and walk context
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ctx_r   <= CTX_TOPKEY;
      inner_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ctx_r   <= ctx_nxt;
      inner_r <= inner_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crc_frame_receiver_classifier.sv =====
// Top level of the magic/length/CRC-16 framed request receiver and classifier.
// Each accepted beat appends one byte to a circular frame store; a sequencer then
// resyncs on AA 55, checks the body length and CRC-16/CCITT-FALSE, walks the
// protobuf body and emits a header beat plus passthrough data beats. All work goes
// through the store's single read port, one byte per read with registered data; a
// byte that completes no frame may still cost a resync scan over the stored bytes,
// and a completing byte adds a CRC pass over the body, the field walk and the data
// beats, plus any output stall. The store needs no clearing pass after reset.
// chunk_last does not affect results.
`default_nettype none

module crc_frame_receiver_classifier #(
  parameter int STORE_BYTES = crcfr_pkg::STORE_BYTES_DEF,
  parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  crcfr_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output crcfr_pkg::out_beat_t out_data,
  input  wire                  cfg_we,
  input  wire                  cfg_wdata
);

  crcfr_pkg::dp_cmd_t  cmd;
  crcfr_pkg::dp_stat_t stat;

  // Sequencer
  crcfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, checks and result register
  crcfr_dp #(
    .STORE_BYTES (STORE_BYTES),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_byte   (in_data.rx_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== sim/frame_scoreboard.sv =====
// Checker for the framed request receiver: predicts request beats and compares them.
`default_nettype none

module frame_scoreboard (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_ready,
  input  crcfr_pkg::in_beat_t  in_data,
  input  wire                  out_valid,
  input  wire                  out_ready,
  input  crcfr_pkg::out_beat_t out_data,
  input  wire                  cfg_we,
  input  wire                  cfg_wdata,
  output int                   err_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE   = crcfr_pkg::STORE_BYTES_DEF;
  localparam int MAX_LEN = crcfr_pkg::MAX_PAYLOAD_DEF + 16;

  logic [7:0] rx_bytes[STORE];
  int         rx_fill;
  logic       reports_on;
  crcfr_pkg::out_beat_t req_queue[$];

  initial err_count = 0;
  assign pending = req_queue.size();

  // Print one mismatch line and count it
  task automatic report(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [7:0] byte_at(input int i);
    return (i < STORE) ? rx_bytes[i] : 8'h00;
  endfunction

  task automatic drop_bytes(input int n);
    if (n >= rx_fill) begin
      rx_fill = 0;
      return;
    end
    for (int i = 0; i < rx_fill - n; i++) rx_bytes[i] = rx_bytes[i + n];
    rx_fill -= n;
  endtask

  // Decode one varint inside [base, base+len); pos is relative to base
  function automatic bit read_varint(input int base, input int len, inout int pos,
                                     output logic [31:0] val);
    logic [31:0] acc;
    int sh;
    logic [7:0] b;
    acc = '0;
    sh = 0;
    val = '0;
    while (pos < len && sh < 32) begin
      b = byte_at(base + pos);
      pos++;
      acc |= 32'(b & 8'h7F) << sh;
      if (!b[7]) begin
        val = acc;
        return 1'b1;
      end
      sh += 7;
    end
    return 1'b0;
  endfunction

  // Walk the body; returns kind or -1 when malformed
  function automatic int request_kind(input int base, input int blen,
                                      output int dstart, output int dlen);
    int pos, sp, sb, l;
    logic [31:0] key, v, sk, sl;
    pos = 0;
    dstart = 0;
    dlen = 0;
    while (pos < blen) begin
      if (!read_varint(base, blen, pos, key)) return -1;
      if (key[2:0] == crcfr_pkg::WT_VARINT) begin
        if (!read_varint(base, blen, pos, v)) return -1;
      end else if (key[2:0] == crcfr_pkg::WT_LEN) begin
        if (!read_varint(base, blen, pos, v)) return -1;
        if (longint'(pos) + longint'(v) > blen) return -1;
        l = int'(v);
        if (key[31:3] == crcfr_pkg::FLD_INFO) return crcfr_pkg::KIND_INFO;
        if (key[31:3] == crcfr_pkg::FLD_STATUS) return crcfr_pkg::KIND_STATUS;
        if (key[31:3] == crcfr_pkg::FLD_CLEAR) return crcfr_pkg::KIND_CLEAR;
        if (key[31:3] != crcfr_pkg::FLD_PASS) return crcfr_pkg::KIND_OTHER;
        sb = base + pos;
        sp = 0;
        while (sp < l) begin
          if (!read_varint(sb, l, sp, sk)) break;
          if (sk[2:0] == crcfr_pkg::WT_LEN) begin
            if (!read_varint(sb, l, sp, sl)) break;
            if (longint'(sp) + longint'(sl) > l) break;
            if (sk[31:3] == crcfr_pkg::FLD_DATA) begin
              dstart = sb + sp;
              dlen = int'(sl);
              return crcfr_pkg::KIND_PASS;
            end
            sp += int'(sl);
          end else if (sk[2:0] == crcfr_pkg::WT_VARINT) begin
            if (!read_varint(sb, l, sp, v)) break;
          end else if (sk[2:0] == crcfr_pkg::WT_FIXED32) sp += 4;
          else if (sk[2:0] == crcfr_pkg::WT_FIXED64) sp += 8;
          else break;
        end
        return crcfr_pkg::KIND_PASS;
      end else if (key[2:0] == crcfr_pkg::WT_FIXED32) pos += 4;
      else if (key[2:0] == crcfr_pkg::WT_FIXED64) pos += 8;
      else return -1;
    end
    return -1;
  endfunction

  // Append one byte and extract every complete frame
  task automatic absorb_byte(input logic [7:0] b);
    int j, blen, kind, ds, dl, len, nb, room, made;
    logic [15:0] crc;
    crcfr_pkg::out_beat_t r;
    made = 0;
    if (rx_fill >= STORE) drop_bytes(1);
    rx_bytes[rx_fill] = b;
    rx_fill++;
    forever begin
      if (rx_fill < 4) break;
      if (!(rx_bytes[0] == crcfr_pkg::MAGIC0 && rx_bytes[1] == crcfr_pkg::MAGIC1)) begin
        j = 1;
        while (j < rx_fill && rx_bytes[j] != crcfr_pkg::MAGIC0) j++;
        drop_bytes(j);
        if (rx_fill < 4) break;
        if (!(rx_bytes[0] == crcfr_pkg::MAGIC0 && rx_bytes[1] == crcfr_pkg::MAGIC1)) begin
          if (rx_bytes[1] != crcfr_pkg::MAGIC1) drop_bytes(1);
          continue;
        end
      end
      blen = int'({rx_bytes[2], rx_bytes[3]});
      if (blen > MAX_LEN) begin
        drop_bytes(2);
        continue;
      end
      if (rx_fill < blen + 6) break;
      crc = crcfr_pkg::CRC_SEED;
      for (int i = 0; i < blen; i++) begin
        crc ^= {rx_bytes[4 + i], 8'h00};
        for (int k = 0; k < 8; k++)
          crc = crc[15] ? ({crc[14:0], 1'b0} ^ crcfr_pkg::CRC_POLY) : {crc[14:0], 1'b0};
      end
      if (crc != {rx_bytes[4 + blen], rx_bytes[5 + blen]}) begin
        drop_bytes(2);
        continue;
      end
      if (reports_on) begin
        kind = request_kind(4, blen, ds, dl);
        if (kind >= 0 && made < crcfr_pkg::MAX_RESULTS) begin
          len = (dl > 63) ? 63 : dl;
          room = crcfr_pkg::MAX_RESULTS - made - 1;
          nb = (len < room) ? len : room;
          r = '{req_kind: 3'(kind), payload_len: 6'(len), has_byte: 1'b0,
                payload_byte: 8'h00, last: (nb == 0)};
          req_queue.push_back(r);
          made++;
          for (int i = 0; i < nb; i++) begin
            r.has_byte = 1'b1;
            r.payload_byte = byte_at(ds + i);
            r.last = (i + 1 == nb);
            req_queue.push_back(r);
            made++;
          end
        end
      end
      drop_bytes(blen + 6);
    end
  endtask

  // Track config, predict on input beats, compare output beats
  always @(posedge clk) begin
    crcfr_pkg::out_beat_t exp_beat;
    if (!rst_n) begin
      rx_fill = 0;
      reports_on = 1'b1;
    end else begin
      if (cfg_we) reports_on = cfg_wdata;
      if (in_valid && in_ready) absorb_byte(in_data.rx_byte);
      if (out_valid && out_ready) begin
        if (req_queue.size() == 0) begin
          report($sformatf("unexpected beat %h", out_data));
        end else begin
          exp_beat = req_queue.pop_front();
          if (out_data.req_kind !== exp_beat.req_kind)
            report($sformatf("req_kind %0d want %0d", out_data.req_kind, exp_beat.req_kind));
          if (out_data.payload_len !== exp_beat.payload_len)
            report($sformatf("payload_len %0d want %0d", out_data.payload_len,
                             exp_beat.payload_len));
          if (out_data.has_byte !== exp_beat.has_byte)
            report($sformatf("has_byte %b want %b", out_data.has_byte, exp_beat.has_byte));
          if (out_data.payload_byte !== exp_beat.payload_byte)
            report($sformatf("payload_byte %h want %h", out_data.payload_byte,
                             exp_beat.payload_byte));
          if (out_data.last !== exp_beat.last)
            report($sformatf("last %b want %b", out_data.last, exp_beat.last));
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Stimulus top for the framed request receiver: frames, noise, idling and verdict.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  crcfr_pkg::in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  crcfr_pkg::out_beat_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b1;
  int        err_count, pending;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_off = 0;
  int        quiet_cycles = 0;
  int        sent_bytes = 0;
  logic [7:0] frame_buf[$];

  crc_frame_receiver_classifier DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  frame_scoreboard checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .err_count(err_count), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random stall, or a counted long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n || hold_off > 0)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one byte and hold it until accepted; valid stays up until an idle or wait_idle drops it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{rx_byte: b, chunk_last: 1'($urandom_range(1))};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_bytes++;
  endtask

  // Wrap frame_buf as a body: magic, length, body, CRC; optionally corrupt the CRC
  task automatic send_frame(input bit bad_crc);
    logic [15:0] crc, blen;
    crc = crcfr_pkg::CRC_SEED;
    foreach (frame_buf[i]) begin
      crc ^= {frame_buf[i], 8'h00};
      for (int k = 0; k < 8; k++)
        crc = crc[15] ? ({crc[14:0], 1'b0} ^ crcfr_pkg::CRC_POLY) : {crc[14:0], 1'b0};
    end
    if (bad_crc) crc ^= 16'(1 << $urandom_range(15));
    blen = 16'(frame_buf.size());
    send_byte(crcfr_pkg::MAGIC0);
    send_byte(crcfr_pkg::MAGIC1);
    send_byte(blen[15:8]);
    send_byte(blen[7:0]);
    foreach (frame_buf[i]) send_byte(frame_buf[i]);
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
  endtask

  // Build a body of a given shape into frame_buf
  task automatic build_body(input int shape, input int data_len);
    logic [7:0] key;
    frame_buf.delete();
    case (shape)
      0: begin
        // passthrough with inner data field, sometimes behind a varint
        if ($urandom_range(1)) begin
          frame_buf.push_back({5'd7, crcfr_pkg::WT_VARINT});
          frame_buf.push_back(8'($urandom_range(127)));
        end
        frame_buf.push_back({5'(crcfr_pkg::FLD_PASS), crcfr_pkg::WT_LEN});
        frame_buf.push_back(8'(data_len + 2));
        frame_buf.push_back({5'(crcfr_pkg::FLD_DATA), crcfr_pkg::WT_LEN});
        frame_buf.push_back(8'(data_len));
        for (int i = 0; i < data_len; i++) frame_buf.push_back(8'($urandom));
      end
      1, 2, 3: begin
        key = (shape == 1) ? {5'(crcfr_pkg::FLD_INFO), crcfr_pkg::WT_LEN} :
              (shape == 2) ? {5'(crcfr_pkg::FLD_STATUS), crcfr_pkg::WT_LEN} :
                             {5'(crcfr_pkg::FLD_CLEAR), crcfr_pkg::WT_LEN};
        if ($urandom_range(1)) begin
          frame_buf.push_back({5'd9, crcfr_pkg::WT_FIXED32});
          repeat (4) frame_buf.push_back(8'($urandom));
        end
        frame_buf.push_back(key);
        frame_buf.push_back(8'(data_len));
        for (int i = 0; i < data_len; i++) frame_buf.push_back(8'($urandom));
      end
      4: begin
        frame_buf.push_back({5'($urandom_range(6, 31)), crcfr_pkg::WT_LEN});
        frame_buf.push_back(8'h00);
      end
      5: begin
        // passthrough without data field
        frame_buf.push_back({5'(crcfr_pkg::FLD_PASS), crcfr_pkg::WT_LEN});
        frame_buf.push_back(8'h02);
        frame_buf.push_back({5'd2, crcfr_pkg::WT_VARINT});
        frame_buf.push_back(8'h01);
      end
      default: begin
        // malformed: random bytes, including bad wire types and long varints
        repeat ($urandom_range(1, 10)) frame_buf.push_back(8'($urandom));
      end
    endcase
  endtask

  // Drop valid and let every predicted beat drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_report_enable(input logic v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random phase: mostly well formed frames, some broken frames and noise
  task automatic random_phase(input int n_bytes);
    int pick, stop_at;
    stop_at = sent_bytes + n_bytes;
    while (sent_bytes < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        build_body($urandom_range(6), ($urandom_range(9) == 0) ? $urandom_range(40)
                                                              : $urandom_range(6));
        send_frame(1'b0);
      end else if (pick < 80) begin
        build_body($urandom_range(6), $urandom_range(4));
        send_frame(1'b1);
      end else if (pick < 88) begin
        // oversized length
        send_byte(crcfr_pkg::MAGIC0);
        send_byte(crcfr_pkg::MAGIC1);
        send_byte(8'($urandom_range(1)));
        send_byte(8'($urandom_range(57, 255)));
      end else begin
        repeat ($urandom_range(1, 6))
          send_byte(($urandom_range(3) == 0) ? crcfr_pkg::MAGIC0 : 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: each request kind, extremes, resync and error cases
    write_report_enable(1'b1);
    for (int s = 0; s < 7; s++) begin
      build_body(s, (s == 0) ? 0 : 1);
      send_frame(1'b0);
    end
    build_body(0, 50);
    send_frame(1'b0);
    build_body(2, 1);
    send_frame(1'b1);
    send_byte(8'hFF);
    send_byte(crcfr_pkg::MAGIC0);
    send_byte(crcfr_pkg::MAGIC0);
    send_byte(8'h00);
    send_byte(crcfr_pkg::MAGIC0);
    send_byte(crcfr_pkg::MAGIC1);
    send_byte(8'hFF);
    send_byte(8'hFF);
    frame_buf.delete();
    repeat (5) frame_buf.push_back(8'hFF);
    send_frame(1'b0);
    wait_idle();

    // Phase: no idling
    random_phase(60);
    wait_idle();
    // Phase: sender idle most of the time
    send_idle_pct = 78;
    random_phase(50);
    wait_idle();
    write_report_enable(1'b0);
    send_idle_pct = 0;
    random_phase(30);
    wait_idle();
    write_report_enable(1'b1);
    // Phase: receiver stalls, with one long hold-off
    recv_stall_pct = 78;
    hold_off = 600;
    random_phase(70);
    wait_idle();
    // Phase: both idle
    send_idle_pct = 33;
    recv_stall_pct = 33;
    random_phase(60);
    wait_idle();

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
